[src/lpf_pkg.sv]
// Shared constants and controller/datapath interface types for the palindrome finder.
package lpf_pkg;

  localparam int MAX_LEN_DEF = 64;
  localparam int CHAR_W      = 8;
  localparam int START_W     = 6;
  localparam int LENGTH_W    = 7;
  localparam int IN_DATA_W   = 8;
  localparam int OUT_DATA_W  = 16;

  typedef struct packed {
    logic load;
    logic init;
    logic step;
    logic clear;
  } lpf_cmd_t;

  typedef struct packed {
    logic short_str;
    logic last_len;
  } lpf_status_t;

endpackage

[src/lpf_ctrl.sv]
// Controller state machine that sequences loading, the length passes and the result handoff.
module lpf_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic                 in_tlast,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output lpf_pkg::lpf_cmd_t    cmd,
  input  lpf_pkg::lpf_status_t status
);

  typedef enum logic [4:0] {
    ST_LOAD   = 5'b00001,
    ST_INIT   = 5'b00010,
    ST_SEARCH = 5'b00100,
    ST_DRAIN  = 5'b01000,
    ST_OUT    = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt  = state_r;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    cmd        = '0;
    unique case (state_r)
      ST_LOAD: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load = 1'b1;
          if (in_tlast) state_nxt = ST_INIT;
        end
      end
      ST_INIT: begin
        cmd.init  = 1'b1;
        state_nxt = status.short_str ? ST_DRAIN : ST_SEARCH;
      end
      ST_SEARCH: begin
        cmd.step = 1'b1;
        if (status.last_len) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          cmd.clear = 1'b1;
          state_nxt = ST_LOAD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[src/lpf_dp.sv]
// Datapath holding the string, the two stored diagonals and the best-match registers.
module lpf_dp #(
  parameter int MAX_LEN = lpf_pkg::MAX_LEN_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  lpf_pkg::lpf_cmd_t            cmd,
  output lpf_pkg::lpf_status_t         status,
  input  logic [lpf_pkg::CHAR_W-1:0]   char_byte,
  output logic [lpf_pkg::START_W-1:0]  best_start,
  output logic [lpf_pkg::LENGTH_W-1:0] best_length,
  output logic                         overflow
);

  localparam int IW = $clog2(MAX_LEN);
  localparam int CW = $clog2(MAX_LEN + 1);

  logic [lpf_pkg::CHAR_W-1:0] str_r [MAX_LEN];
  logic [lpf_pkg::CHAR_W-1:0] shf_r [MAX_LEN];
  logic [CW-1:0]      count_r, len_r, cur_len_r, best_len_r;
  logic [IW-1:0]      best_start_r, last_idx;
  logic               ovf_r, cur_vld_r;
  logic [MAX_LEN-1:0] p2_r, p1_r, mask_r, cur_r;
  logic [MAX_LEN-1:0] eq, cur, fill;
  logic               full;

  assign full = (count_r == CW'(MAX_LEN));

  always_comb begin
    for (int i = 0; i < MAX_LEN; i++) begin
      eq[i]   = (str_r[i] == shf_r[i]);
      fill[i] = (CW'(i) < count_r);
    end
    cur = eq & (p2_r >> 1) & mask_r;
  end

  always_comb begin
    last_idx = '0;
    for (int i = 0; i < MAX_LEN; i++) begin
      if (cur_r[i]) last_idx = IW'(i);
    end
  end

  assign status.short_str = (count_r < CW'(2));
  assign status.last_len  = (len_r == count_r);

  always_ff @(posedge clk) begin
    if (cmd.load && !full) begin
      str_r[count_r[IW-1:0]] <= char_byte;
    end
    if (cmd.init) begin
      for (int i = 0; i < MAX_LEN - 1; i++) shf_r[i] <= str_r[i+1];
      shf_r[MAX_LEN-1] <= '0;
      mask_r <= fill >> 1;
      p2_r   <= '1;
      p1_r   <= '1;
      len_r  <= CW'(2);
    end else if (cmd.step) begin
      for (int i = 0; i < MAX_LEN - 1; i++) shf_r[i] <= shf_r[i+1];
      mask_r <= mask_r >> 1;
      p2_r   <= p1_r;
      p1_r   <= cur;
      len_r  <= len_r + CW'(1);
    end
    cur_r     <= cur;
    cur_len_r <= len_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      ovf_r        <= 1'b0;
      cur_vld_r    <= 1'b0;
      best_len_r   <= CW'(1);
      best_start_r <= '0;
    end else begin
      cur_vld_r <= cmd.step;
      if (cmd.clear) begin
        count_r <= '0;
        ovf_r   <= 1'b0;
      end else if (cmd.load) begin
        if (full) ovf_r <= 1'b1;
        else count_r <= count_r + CW'(1);
      end
      if (cmd.init) begin
        best_len_r   <= CW'(1);
        best_start_r <= '0;
      end else if (cur_vld_r && (cur_r != '0)) begin
        best_len_r   <= cur_len_r;
        best_start_r <= last_idx;
      end
    end
  end

  assign best_start  = lpf_pkg::START_W'(best_start_r);
  assign best_length = lpf_pkg::LENGTH_W'(best_len_r);
  assign overflow    = ovf_r;

endmodule

[src/longest_palindrome_finder.sv]
// Top level of the longest palindromic substring finder.
// The input channel takes one string byte per item in in_tdata, with in_tlast high on the
// final byte. Bytes are taken one per cycle while loading; bytes past MAX_LEN are dropped
// and the overflow flag is set, and a dropped byte with in_tlast still ends the string.
// After the final byte, a setup state loads the diagonal registers, then a search state
// steps through palindrome lengths 2 to n, checking every start of each length at once,
// and a drain state commits the last length; a string shorter than two bytes skips the
// search. Here n is the length of the string in bytes, capped at MAX_LEN.
// The result item carries the start and length in out_tdata and the overflow flag in
// out_tuser. While out_tvalid waits for out_tready the result holds and in_tready stays
// low; the next string is taken after the result is accepted. One string is handled at a
// time. A synchronous reset (rst_n low) returns the block to loading with an empty string.
module longest_palindrome_finder #(
  parameter int MAX_LEN = lpf_pkg::MAX_LEN_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [lpf_pkg::IN_DATA_W-1:0]    in_tdata,  // [7:0] char_byte
  input  logic                             in_tlast,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [lpf_pkg::OUT_DATA_W-1:0]   out_tdata, // [5:0] best_start, [12:6] best_length
  output logic                             out_tuser  // [0] overflow
);

  lpf_pkg::lpf_cmd_t            cmd;
  lpf_pkg::lpf_status_t         status;
  logic [lpf_pkg::START_W-1:0]  best_start;
  logic [lpf_pkg::LENGTH_W-1:0] best_length;

  lpf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .status     (status)
  );

  lpf_dp #(
    .MAX_LEN (MAX_LEN)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .status      (status),
    .char_byte   (in_tdata[lpf_pkg::CHAR_W-1:0]),
    .best_start  (best_start),
    .best_length (best_length),
    .overflow    (out_tuser)
  );

  assign out_tdata = {
    (lpf_pkg::OUT_DATA_W - lpf_pkg::START_W - lpf_pkg::LENGTH_W)'(0),
    best_length,
    best_start
  };

endmodule

[tb/tb_longest_palindrome_finder.sv]
// Testbench for the longest palindrome finder: directed and random strings checked against a predictor.
`timescale 1ns / 100ps

module tb_longest_palindrome_finder;

  localparam int MAX_LEN     = lpf_pkg::MAX_LEN_DEF;
  localparam int ITEM_TARGET = 650;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 2 * MAX_LEN + 20;

  typedef struct packed {
    logic [lpf_pkg::START_W-1:0]  best_start;
    logic [lpf_pkg::LENGTH_W-1:0] best_length;
    logic                         overflow;
  } pal_result_t;

  typedef struct packed {
    logic [7:0]  char_byte;
    logic        last;
    logic        typed;
    pal_result_t res;
  } dir_row_t;

  localparam int DIR_ROWS = 20;

  // The typed rows end strings whose answer is obvious; the rest go through the predictor.
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    '{8'h00, 1'b1, 1'b1, '{6'd0, 7'd1, 1'b0}},
    '{8'hFF, 1'b1, 1'b1, '{6'd0, 7'd1, 1'b0}},
    '{8'h01, 1'b0, 1'b0, '{6'd0, 7'd0, 1'b0}},
    '{8'h02, 1'b1, 1'b1, '{6'd0, 7'd1, 1'b0}},
    '{8'hAA, 1'b0, 1'b0, '{6'd0, 7'd0, 1'b0}},
    '{8'hAA, 1'b1, 1'b1, '{6'd0, 7'd2, 1'b0}},
    '{8'h80, 1'b0, 1'b0, '{6'd0, 7'd0, 1'b0}},
    '{8'h7F, 1'b0, 1'b0, '{6'd0, 7'd0, 1'b0}},
    '{8'h80, 1'b1, 1'b0, '{6'd0, 7'd0, 1'b0}},
    '{8'h61, 1'b0, 1'b0, '{6'd0, 7'd0, 1'b0}},
    '{8'h62, 1'b0, 1'b0, '{6'd0, 7'd0, 1'b0}},
    '{8'h63, 1'b0, 1'b0, '{6'd0, 7'd0, 1'b0}},
    '{8'h62, 1'b1, 1'b0, '{6'd0, 7'd0, 1'b0}},
    '{8'h61, 1'b0, 1'b0, '{6'd0, 7'd0, 1'b0}},
    '{8'h61, 1'b0, 1'b0, '{6'd0, 7'd0, 1'b0}},
    '{8'h62, 1'b0, 1'b0, '{6'd0, 7'd0, 1'b0}},
    '{8'h62, 1'b1, 1'b0, '{6'd0, 7'd0, 1'b0}},
    '{8'h55, 1'b0, 1'b0, '{6'd0, 7'd0, 1'b0}},
    '{8'h55, 1'b0, 1'b0, '{6'd0, 7'd0, 1'b0}},
    '{8'h55, 1'b1, 1'b0, '{6'd0, 7'd0, 1'b0}}
  };

  logic                          clk;
  logic                          rst_n;
  logic                          in_tvalid;
  logic                          in_tready;
  logic [lpf_pkg::IN_DATA_W-1:0]  in_tdata;
  logic                          in_tlast;
  logic                          out_tvalid;
  logic                          out_tready;
  logic [lpf_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                          out_tuser;

  pal_result_t pending_results [$];
  pal_result_t want_res;
  pal_result_t got_res;
  logic [7:0]  text_buf [MAX_LEN];
  int          text_len;
  logic        text_ovf;
  int          items_sent;
  int          error_count;
  int          cycle_count;
  logic        send_idle;
  logic        recv_idle;
  logic        hold_req;

  longest_palindrome_finder #(
    .MAX_LEN(MAX_LEN)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  // Interval search over the bytes kept for the current string, two diagonals deep.
  function automatic pal_result_t find_longest();
    logic [MAX_LEN:0] two_back;
    logic [MAX_LEN:0] one_back;
    logic [MAX_LEN:0] this_len;
    pal_result_t      r;
    two_back      = '1;
    one_back      = '1;
    r.best_start  = '0;
    r.best_length = 7'd1;
    r.overflow    = text_ovf;
    for (int len = 2; len <= text_len; len++) begin
      this_len = '0;
      for (int i = 0; i + len <= text_len; i++) begin
        if (text_buf[i] == text_buf[i + len - 1] && two_back[i + 1]) begin
          this_len[i]   = 1'b1;
          r.best_length = len[lpf_pkg::LENGTH_W-1:0];
          r.best_start  = i[lpf_pkg::START_W-1:0];
        end
      end
      two_back = one_back;
      one_back = this_len;
    end
    return r;
  endfunction

  function automatic int pick_gap(input logic idle_on);
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_item(input logic [7:0] ch, input logic fin, input logic typed,
                           input pal_result_t typed_res);
    int gap;
    in_tvalid = 1'b1;
    in_tdata  = ch;
    in_tlast  = fin;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
    if (text_len < MAX_LEN) begin
      text_buf[text_len] = ch;
      text_len++;
    end else begin
      text_ovf = 1'b1;
    end
    if (fin) begin
      pending_results = {pending_results, (typed ? typed_res : find_longest())};
      text_len = 0;
      text_ovf = 1'b0;
    end
    gap = pick_gap(send_idle);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send_string(input int n);
    logic [7:0] s [128];
    logic [7:0] base;
    int         style;
    int         half;
    int         pos;
    style = $urandom_range(0, 3);
    base  = 8'($urandom);
    for (int i = 0; i < n; i++) begin
      unique case (style)
        0: s[i] = 8'($urandom);
        1, 2: s[i] = base + 8'($urandom_range(0, 1));
        default: s[i] = base;
      endcase
    end
    // Mirror a random stretch so that long palindromes show up inside noise.
    if (style == 2 && n >= 4) begin
      half = $urandom_range(1, n / 2);
      pos  = $urandom_range(0, n - 2 * half);
      for (int k = 0; k < half; k++) begin
        s[pos + k] = 8'($urandom);
        s[pos + 2 * half - 1 - k] = s[pos + k];
      end
    end
    for (int i = 0; i < n; i++) begin
      send_item(s[i], i == n - 1, 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_res.best_start  = out_tdata[5:0];
      got_res.best_length = out_tdata[12:6];
      got_res.overflow    = out_tuser;
      if (pending_results.size() == 0) begin
        $error("Unexpected result item: best_start %0d, best_length %0d, overflow %0b.",
               got_res.best_start, got_res.best_length, got_res.overflow);
        error_count++;
      end else begin
        want_res = pending_results.pop_front();
        if (got_res.best_start !== want_res.best_start) begin
          $error("best_start mismatch: expected %0d, actual %0d.",
                 want_res.best_start, got_res.best_start);
          error_count++;
        end
        if (got_res.best_length !== want_res.best_length) begin
          $error("best_length mismatch: expected %0d, actual %0d.",
                 want_res.best_length, got_res.best_length);
          error_count++;
        end
        if (got_res.overflow !== want_res.overflow) begin
          $error("overflow mismatch: expected %0b, actual %0b.",
                 want_res.overflow, got_res.overflow);
          error_count++;
        end
      end
    end
  end

  initial begin
    int   stall_left;
    int   mode_left;
    logic hold_done;
    out_tready = 1'b0;
    stall_left = 0;
    mode_left  = 0;
    hold_done  = 1'b0;
    recv_idle  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end
      if (mode_left == 0) begin
        recv_idle = ($urandom_range(0, 3) != 0);
        mode_left = $urandom_range(50, 300);
      end else begin
        mode_left--;
      end
      if (stall_left > 0) begin
        out_tready = 1'b0;
        stall_left--;
      end else begin
        out_tready = 1'b1;
        stall_left = pick_gap(recv_idle);
      end
    end
  end

  initial begin
    int strings_sent;
    int r;
    int n;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tlast    = 1'b0;
    hold_req    = 1'b0;
    send_idle   = 1'b0;
    text_len    = 0;
    text_ovf    = 1'b0;
    items_sent  = 0;
    error_count = 0;
    strings_sent = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int row = 0; row < DIR_ROWS; row++) begin
      if (row == 0 || DIRECTED[row - 1].last) send_idle = $urandom_range(0, 1);
      send_item(DIRECTED[row].char_byte, DIRECTED[row].last, DIRECTED[row].typed,
                DIRECTED[row].res);
    end

    while (items_sent < ITEM_TARGET) begin
      send_idle = ($urandom_range(0, 3) != 0);
      if (strings_sent == 15) hold_req = 1'b1;
      if (strings_sent == 40) begin
        in_tvalid = 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
        @(negedge clk);
      end
      r = $urandom_range(0, 99);
      if (r < 65) n = $urandom_range(1, 10);
      else if (r < 85) n = $urandom_range(11, 30);
      else if (r < 93) n = $urandom_range(31, 63);
      else if (r < 95) n = MAX_LEN;
      else if (r < 97) n = MAX_LEN + 1;
      else n = $urandom_range(MAX_LEN + 2, MAX_LEN + 26);
      send_string(n);
      strings_sent++;
    end
    in_tvalid = 1'b0;
    in_tlast  = 1'b0;

    while (pending_results.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
